// File: hw/rtl/ihs_pkg.sv
`default_nettype none
package ihs_pkg;

  // JPEG segment walker phases
  localparam logic [3:0] PH_MARK       = 4'd0;
  localparam logic [3:0] PH_TYPE       = 4'd1;
  localparam logic [3:0] PH_LEN_HI     = 4'd2;
  localparam logic [3:0] PH_LEN_LO     = 4'd3;
  localparam logic [3:0] PH_SKIP       = 4'd4;
  localparam logic [3:0] PH_PREC       = 4'd5;
  localparam logic [3:0] PH_H_HI       = 4'd6;
  localparam logic [3:0] PH_H_LO       = 4'd7;
  localparam logic [3:0] PH_W_HI       = 4'd8;
  localparam logic [3:0] PH_W_LO       = 4'd9;
  localparam logic [3:0] PH_DONE       = 4'd10;
  localparam logic [3:0] PH_ERR        = 4'd11;
  localparam logic [3:0] PH_SOF_LEN_HI = 4'd12;
  localparam logic [3:0] PH_SOF_LEN_LO = 4'd13;

  // Result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd1;
  localparam logic [2:0] ST_BAD_MARKER  = 3'd2;
  localparam logic [2:0] ST_NO_SIZE     = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE   = 3'd4;

  // Format codes
  localparam logic [1:0] FMT_NONE = 2'd0;
  localparam logic [1:0] FMT_PNG  = 2'd1;
  localparam logic [1:0] FMT_JPEG = 2'd2;

  // JPEG error codes
  localparam logic [1:0] JERR_NONE     = 2'd0;
  localparam logic [1:0] JERR_NO_FF    = 2'd1;
  localparam logic [1:0] JERR_SHORT_LEN = 2'd2;

  // Marker and signature bytes
  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_SOI = 8'hD8;
  localparam logic [7:0] BYTE_EOI = 8'hD9;
  localparam logic [7:0] BYTE_SOF0 = 8'hC0;
  localparam logic [7:0] BYTE_SOF1 = 8'hC1;
  localparam logic [7:0] BYTE_SOF2 = 8'hC2;

  // Byte positions
  localparam logic [4:0] POS_SIG_END  = 5'd8;
  localparam logic [4:0] POS_JPEG_MIN = 5'd2;
  localparam logic [4:0] POS_W_START  = 5'd16;
  localparam logic [4:0] POS_H_START  = 5'd20;
  localparam logic [4:0] POS_SAT      = 5'd24;

  typedef struct packed {
    logic [3:0]  phase;
    logic [15:0] skip;
    logic [1:0]  err;
  } walk_state_t;

  typedef struct packed {
    logic h_hi;
    logic h_lo;
    logic w_hi;
    logic w_lo;
  } dim_load_t;

  typedef struct packed {
    logic [30:0] height;
    logic [30:0] width;
    logic [1:0]  format;
    logic [2:0]  status;
  } result_t;

  localparam walk_state_t WALK_RESET = '{phase: PH_MARK, skip: 16'd0, err: JERR_NONE};

  function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h89;
      3'd1:    v = 8'h50;
      3'd2:    v = 8'h4E;
      3'd3:    v = 8'h47;
      3'd4:    v = 8'h0D;
      3'd5:    v = 8'h0A;
      3'd6:    v = 8'h1A;
      3'd7:    v = 8'h0A;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ihs_jpeg_walk.sv
`default_nettype none
module ihs_jpeg_walk (
  input  wire logic                 en,
  input  wire logic [7:0]           byte_in,
  input  wire ihs_pkg::walk_state_t cur,
  output ihs_pkg::walk_state_t      nxt,
  output ihs_pkg::dim_load_t        load
);
  import ihs_pkg::*;

  logic [15:0] len;
  logic [15:0] skip_dec;

  assign len      = {cur.skip[7:0], byte_in};
  assign skip_dec = cur.skip - 16'd1;

  always_comb begin
    nxt  = cur;
    load = '0;
    if (en) begin
      case (cur.phase)
        PH_MARK: begin
          if (byte_in != BYTE_FF) begin
            nxt.err   = JERR_NO_FF;
            nxt.phase = PH_ERR;
          end else begin
            nxt.phase = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (byte_in == BYTE_SOF0 || byte_in == BYTE_SOF1 || byte_in == BYTE_SOF2) begin
            nxt.phase = PH_SOF_LEN_HI;
          end else begin
            nxt.phase = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          nxt.skip  = {8'd0, byte_in};
          nxt.phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (len < 16'd2) begin
            nxt.err   = JERR_SHORT_LEN;
            nxt.phase = PH_ERR;
            nxt.skip  = 16'd0;
          end else begin
            nxt.skip  = len - 16'd2;
            nxt.phase = (len == 16'd2) ? PH_MARK : PH_SKIP;
          end
        end
        PH_SKIP: begin
          nxt.skip = skip_dec;
          if (skip_dec == 16'd0) begin
            nxt.phase = PH_MARK;
          end
        end
        PH_SOF_LEN_HI: nxt.phase = PH_SOF_LEN_LO;
        PH_SOF_LEN_LO: nxt.phase = PH_PREC;
        PH_PREC:       nxt.phase = PH_H_HI;
        PH_H_HI: begin
          load.h_hi = 1'b1;
          nxt.phase = PH_H_LO;
        end
        PH_H_LO: begin
          load.h_lo = 1'b1;
          nxt.phase = PH_W_HI;
        end
        PH_W_HI: begin
          load.w_hi = 1'b1;
          nxt.phase = PH_W_LO;
        end
        PH_W_LO: begin
          load.w_lo = 1'b1;
          nxt.phase = PH_DONE;
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ihs_classify.sv
`default_nettype none
module ihs_classify (
  input  wire logic                 png_match,
  input  wire logic                 jpeg_match,
  input  wire logic [4:0]           pos,
  input  wire logic [15:0]          recent,
  input  wire ihs_pkg::walk_state_t walk,
  input  wire logic [31:0]          width_val,
  input  wire logic [31:0]          height_val,
  output ihs_pkg::result_t          res
);
  import ihs_pkg::*;

  always_comb begin
    res.status = ST_UNSUPPORTED;
    res.format = FMT_NONE;
    res.width  = 31'd0;
    res.height = 31'd0;
    if (png_match && pos >= POS_SIG_END) begin
      res.format = FMT_PNG;
      if (pos < POS_SAT) begin
        res.status = ST_NO_SIZE;
      end else if (width_val[31] || height_val[31]) begin
        res.status = ST_TOO_LARGE;
      end else begin
        res.status = ST_OK;
        res.width  = width_val[30:0];
        res.height = height_val[30:0];
      end
    end else if (jpeg_match && pos >= POS_JPEG_MIN && recent == {BYTE_FF, BYTE_EOI}) begin
      res.format = FMT_JPEG;
      if (walk.err != JERR_NONE) begin
        res.status = ST_BAD_MARKER;
      end else if (walk.phase != PH_DONE || width_val == 32'd0 || height_val == 32'd0) begin
        res.status = ST_NO_SIZE;
      end else begin
        res.status = ST_OK;
        res.width  = width_val[30:0];
        res.height = height_val[30:0];
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/image_header_size_sniffer.sv
`default_nettype none
// The result of a file is registered and appears on the output in the cycle after the beat carrying tlast.
// Throughput: one byte beat per cycle; the per-byte state update is a single registered pass.
// The input stalls only while a finished result waits in the output register untaken.
// Reset: synchronous, active low on rst_n; clears the parser state and the output valid.
// After every final byte the parser returns to its reset state, ready for the next file.
module image_header_size_sniffer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [7:0] byte_value
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tlast,   // last_byte
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: [2:0] status, [4:3] format, [35:5] image_width,
  //            [66:36] image_height, [71:67] zero
  output logic [71:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready
);
  import ihs_pkg::*;

  // Parser state, all updated in one pass per accepted byte beat.
  logic [4:0]  pos_r, pos_nxt;
  logic        png_r, png_nxt;
  logic        jpg_r, jpg_nxt;
  walk_state_t walk_r, walk_nxt;
  logic [31:0] wid_r, wid_nxt;
  logic [31:0] hgt_r, hgt_nxt;
  logic [15:0] recent_r, recent_nxt;

  // Output register
  logic        out_valid_r;
  result_t     out_res_r;

  logic        in_fire;
  logic        walk_en;
  logic        png_cap;
  dim_load_t   load;
  result_t     res;

  // A new beat is taken whenever the output register is empty or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Signature tracking. The PNG signature covers the first eight bytes; the JPEG start of
  // image marker covers the first two.
  always_comb begin
    png_nxt = png_r;
    jpg_nxt = jpg_r;
    if (pos_r < POS_SIG_END && in_tdata != png_sig_byte(pos_r[2:0])) begin
      png_nxt = 1'b0;
    end
    if (pos_r == 5'd0 && in_tdata != BYTE_FF) begin
      jpg_nxt = 1'b0;
    end
    if (pos_r == 5'd1 && in_tdata != BYTE_SOI) begin
      jpg_nxt = 1'b0;
    end
  end

  // The segment walker runs on every byte from offset two while the file still looks
  // like a JPEG.
  assign walk_en = jpg_r && (pos_r >= POS_JPEG_MIN);

  ihs_jpeg_walk u_walk (
    .en      (walk_en),
    .byte_in (in_tdata),
    .cur     (walk_r),
    .nxt     (walk_nxt),
    .load    (load)
  );

  // PNG width and height are shifted in big-endian from offsets 16 to 23. The same
  // registers hold the 16-bit JPEG dimensions; a file can only ever match one format
  // beyond its first byte, so the two never compete.
  assign png_cap = png_nxt && (pos_r >= POS_W_START) && (pos_r < POS_SAT);

  always_comb begin
    wid_nxt = wid_r;
    hgt_nxt = hgt_r;
    if (png_cap) begin
      if (pos_r < POS_H_START) begin
        wid_nxt = {wid_r[23:0], in_tdata};
      end else begin
        hgt_nxt = {hgt_r[23:0], in_tdata};
      end
    end
    if (load.h_hi) begin
      hgt_nxt = {16'd0, in_tdata, 8'd0};
    end
    if (load.h_lo) begin
      hgt_nxt = {hgt_r[31:8], hgt_r[7:0] | in_tdata};
    end
    if (load.w_hi) begin
      wid_nxt = {16'd0, in_tdata, 8'd0};
    end
    if (load.w_lo) begin
      wid_nxt = {wid_r[31:8], wid_r[7:0] | in_tdata};
    end
  end

  assign recent_nxt = {recent_r[7:0], in_tdata};
  assign pos_nxt    = (pos_r < POS_SAT) ? pos_r + 5'd1 : pos_r;

  // The verdict is formed from the state as it stands after the current byte.
  ihs_classify u_classify (
    .png_match  (png_nxt),
    .jpeg_match (jpg_nxt),
    .pos        (pos_nxt),
    .recent     (recent_nxt),
    .walk       (walk_nxt),
    .width_val  (wid_nxt),
    .height_val (hgt_nxt),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 5'd0;
      png_r    <= 1'b1;
      jpg_r    <= 1'b1;
      walk_r   <= WALK_RESET;
      wid_r    <= 32'd0;
      hgt_r    <= 32'd0;
      recent_r <= 16'd0;
    end else if (in_fire) begin
      if (in_tlast) begin
        pos_r    <= 5'd0;
        png_r    <= 1'b1;
        jpg_r    <= 1'b1;
        walk_r   <= WALK_RESET;
        wid_r    <= 32'd0;
        hgt_r    <= 32'd0;
        recent_r <= 16'd0;
      end else begin
        pos_r    <= pos_nxt;
        png_r    <= png_nxt;
        jpg_r    <= jpg_nxt;
        walk_r   <= walk_nxt;
        wid_r    <= wid_nxt;
        hgt_r    <= hgt_nxt;
        recent_r <= recent_nxt;
      end
    end
  end

  // Output register: loaded by the final byte of a file, emptied when the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_tlast) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r};

  // A final byte always leaves a result waiting in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> out_valid_r)
    else $error("final byte did not produce a result");

  // The parser is back at the start of a file after its final byte.
  a_last_resets_parser: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (pos_r == 5'd0 && png_r && jpg_r))
    else $error("parser state not cleared after final byte");

  // The byte counter saturates.
  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_SAT)
    else $error("byte position beyond saturation");

  // Past the first byte a file can look like at most one format.
  a_one_format: assert property (@(posedge clk) disable iff (!rst_n)
    (png_r && jpg_r) |-> (pos_r == 5'd0))
    else $error("both signatures still match after the first byte");

  // A recorded walker error parks the walker.
  a_err_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (walk_r.err != JERR_NONE) |-> (walk_r.phase == PH_ERR))
    else $error("walker error without error phase");

  // Dimensions are given only with an ok status.
  a_dims_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status != ST_OK) |->
      (out_res_r.width == 31'd0 && out_res_r.height == 31'd0))
    else $error("dimensions reported with a failing status");

endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import ihs_pkg::*;

  // The eight bytes that open every PNG file, first byte in the top bits.
  localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;

  // Cycles for which the receiver refuses every result at the start of the
  // back-pressure phase. The output register fills and the input must stall.
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef enum logic {TP_NORMAL, TP_BACKPRESSURE} test_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  // in_tdata: [7:0] byte_value
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;   // last_byte
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // out_tdata: [2:0] status, [4:3] format, [35:5] image_width,
  //            [66:36] image_height, [71:67] zero
  logic [71:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;

  image_header_size_sniffer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always #5 clk = ~clk;

  // Byte beats waiting to be offered, and the size reports that the files
  // accepted so far must still produce, oldest first.
  beat_t       beat_q[$];
  result_t     due_reports[$];
  logic [7:0]  file_buf[$];

  // Idling is set between phases from the stimulus process, on the falling
  // edge, and only read by the clocked processes on the rising edge.
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  test_phase_t test_phase = TP_NORMAL;
  int          hold_cycles = 0;
  int          fault_count = 0;

  // Our own copy of the parser state, advanced once per accepted beat.
  logic [4:0]  seen_bytes;
  logic        png_still;
  logic        jpeg_still;
  logic [3:0]  walk;
  logic [15:0] skip_cnt;
  logic [31:0] wid;
  logic [31:0] hgt;
  logic [15:0] tail;
  logic [1:0]  jerr;

  task automatic clear_header_state();
    seen_bytes = 5'd0;
    png_still  = 1'b1;
    jpeg_still = 1'b1;
    walk       = PH_MARK;
    skip_cnt   = 16'd0;
    wid        = 32'd0;
    hgt        = 32'd0;
    tail       = 16'd0;
    jerr       = JERR_NONE;
  endtask

  // Advances the parser copy by one byte. On the final byte of a file it
  // decides the report that the block owes and starts afresh.
  task automatic track_header_byte(input logic [7:0] b, input logic last);
    logic [15:0] seg_len;
    result_t     rep;
    if (seen_bytes < POS_SIG_END && b != PNG_MAGIC[8 * (7 - seen_bytes[2:0]) +: 8])
      png_still = 1'b0;
    if (seen_bytes == 5'd0 && b != BYTE_FF) jpeg_still = 1'b0;
    if (seen_bytes == 5'd1 && b != BYTE_SOI) jpeg_still = 1'b0;

    // PNG keeps width and height as big-endian words in the IHDR chunk.
    if (png_still && seen_bytes >= POS_W_START && seen_bytes < POS_SAT) begin
      if (seen_bytes < POS_H_START) wid = {wid[23:0], b};
      else hgt = {hgt[23:0], b};
    end

    // JPEG: walk the marker segments until a start-of-frame turns up.
    if (jpeg_still && seen_bytes >= POS_JPEG_MIN) begin
      case (walk)
        PH_MARK: begin
          if (b != BYTE_FF) begin
            jerr = JERR_NO_FF;
            walk = PH_ERR;
          end else begin
            walk = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (b == BYTE_SOF0 || b == BYTE_SOF1 || b == BYTE_SOF2) walk = PH_SOF_LEN_HI;
          else walk = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          skip_cnt = {8'd0, b};
          walk = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          seg_len = {skip_cnt[7:0], b};
          // A length below two would point back into the segment header.
          if (seg_len < 16'd2) begin
            jerr = JERR_SHORT_LEN;
            walk = PH_ERR;
            skip_cnt = 16'd0;
          end else begin
            skip_cnt = seg_len - 16'd2;
            walk = (skip_cnt == 16'd0) ? PH_MARK : PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_cnt = skip_cnt - 16'd1;
          if (skip_cnt == 16'd0) walk = PH_MARK;
        end
        PH_SOF_LEN_HI: walk = PH_SOF_LEN_LO;
        PH_SOF_LEN_LO: walk = PH_PREC;
        PH_PREC:       walk = PH_H_HI;
        PH_H_HI: begin
          hgt = {16'd0, b, 8'd0};
          walk = PH_H_LO;
        end
        PH_H_LO: begin
          hgt = hgt | {24'd0, b};
          walk = PH_W_HI;
        end
        PH_W_HI: begin
          wid = {16'd0, b, 8'd0};
          walk = PH_W_LO;
        end
        PH_W_LO: begin
          wid = wid | {24'd0, b};
          walk = PH_DONE;
        end
        default: ;
      endcase
    end

    tail = {tail[7:0], b};
    if (seen_bytes < POS_SAT) seen_bytes = seen_bytes + 5'd1;

    if (last) begin
      rep = '0;
      if (png_still && seen_bytes >= POS_SIG_END) begin
        rep.format = FMT_PNG;
        if (seen_bytes < POS_SAT) begin
          rep.status = ST_NO_SIZE;
        end else if (wid[31] || hgt[31]) begin
          rep.status = ST_TOO_LARGE;
        end else begin
          rep.status = ST_OK;
          rep.width  = wid[30:0];
          rep.height = hgt[30:0];
        end
      end else if (jpeg_still && seen_bytes >= POS_JPEG_MIN && tail == {BYTE_FF, BYTE_EOI}) begin
        rep.format = FMT_JPEG;
        if (jerr != JERR_NONE) begin
          rep.status = ST_BAD_MARKER;
        end else if (walk != PH_DONE || wid == 32'd0 || hgt == 32'd0) begin
          rep.status = ST_NO_SIZE;
        end else begin
          rep.status = ST_OK;
          rep.width  = wid[30:0];
          rep.height = hgt[30:0];
        end
      end else begin
        rep.status = ST_UNSUPPORTED;
        rep.format = FMT_NONE;
      end
      due_reports.push_back(rep);
      clear_header_state();
    end
  endtask

  task automatic check_field(input string name, input logic [30:0] want, input logic [30:0] got);
    if (want !== got) begin
      fault_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Sender. A beat is held until taken; a new beat, or an idle cycle, is
  // chosen only once the previous one has gone.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'd0;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) track_header_byte(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= beat_q[0].data;
          in_tlast  <= beat_q[0].last;
          beat_q.delete(0);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Every report beat is compared field by field with the oldest
  // report still due.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[66:0];
        if (due_reports.size() == 0) begin
          fault_count++;
          $display("%0t: report beat with none due, expected nothing, got %h", $time, out_tdata);
        end else begin
          want = due_reports.pop_front();
          check_field("status", {28'd0, want.status}, {28'd0, got.status});
          check_field("format", {29'd0, want.format}, {29'd0, got.format});
          check_field("image_width", want.width, got.width);
          check_field("image_height", want.height, got.height);
          check_field("padding", 31'd0, {26'd0, out_tdata[71:67]});
        end
      end
      if (test_phase == TP_BACKPRESSURE && hold_cycles < HOLD_OFF_CYCLES) begin
        hold_cycles <= hold_cycles + 1;
        out_tready  <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // File builders. Each one leaves a complete file in file_buf.
  task automatic make_png(input logic [31:0] w, input logic [31:0] h, input int extra);
    file_buf.delete();
    for (int i = 0; i < 8; i++) file_buf.push_back(PNG_MAGIC[8 * (7 - i) +: 8]);
    // IHDR chunk length and type, as a real file carries them.
    file_buf.push_back(8'h00);
    file_buf.push_back(8'h00);
    file_buf.push_back(8'h00);
    file_buf.push_back(8'h0D);
    file_buf.push_back(8'h49);
    file_buf.push_back(8'h48);
    file_buf.push_back(8'h44);
    file_buf.push_back(8'h52);
    for (int i = 3; i >= 0; i--) file_buf.push_back(w[8 * i +: 8]);
    for (int i = 3; i >= 0; i--) file_buf.push_back(h[8 * i +: 8]);
    repeat (extra) file_buf.push_back(8'($urandom_range(255)));
  endtask

  // SOI, some segments of other types, the frame header and EOI.
  task automatic make_jpeg(input logic [7:0] sof, input logic [15:0] h, input logic [15:0] w,
                           input int segs, input int min_len, input int max_len);
    logic [15:0] seg_len;
    int          comp_bytes;
    file_buf.delete();
    file_buf.push_back(BYTE_FF);
    file_buf.push_back(BYTE_SOI);
    for (int s = 0; s < segs; s++) begin
      seg_len = 16'($urandom_range(max_len, min_len));
      file_buf.push_back(BYTE_FF);
      file_buf.push_back(8'($urandom_range(8'hFE, 8'hC3)));
      file_buf.push_back(seg_len[15:8]);
      file_buf.push_back(seg_len[7:0]);
      for (int i = 2; i < seg_len; i++) file_buf.push_back(8'($urandom_range(255)));
    end
    file_buf.push_back(BYTE_FF);
    file_buf.push_back(sof);
    file_buf.push_back(8'h00);
    file_buf.push_back(8'h11);
    file_buf.push_back(8'h08);
    file_buf.push_back(h[15:8]);
    file_buf.push_back(h[7:0]);
    file_buf.push_back(w[15:8]);
    file_buf.push_back(w[7:0]);
    comp_bytes = $urandom_range(6);
    repeat (comp_bytes) file_buf.push_back(8'($urandom_range(255)));
    file_buf.push_back(BYTE_FF);
    file_buf.push_back(BYTE_EOI);
  endtask

  task automatic make_noise(input int len);
    file_buf.delete();
    repeat (len) file_buf.push_back(8'($urandom_range(255)));
  endtask

  task automatic trim_file(input int keep);
    while (file_buf.size() > keep) file_buf.delete(file_buf.size() - 1);
  endtask

  // Spoils a well-formed file: a replaced byte, a cut, a lost final byte or
  // a single flipped bit.
  task automatic damage_file();
    int at;
    at = $urandom_range(file_buf.size() - 1);
    case ($urandom_range(3))
      0: file_buf[at] = 8'($urandom_range(255));
      1: trim_file(at + 1);
      2: trim_file(file_buf.size() - 1);
      default: file_buf[at] = file_buf[at] ^ (8'h01 << $urandom_range(7));
    endcase
  endtask

  // Turns file_buf into beats, the tlast flag on the final byte.
  task automatic emit_file();
    beat_t bt;
    foreach (file_buf[i]) begin
      bt.data = file_buf[i];
      bt.last = (i == file_buf.size() - 1);
      beat_q.push_back(bt);
    end
  endtask

  function automatic logic [31:0] pick_png_dim();
    logic [31:0] v;
    case ($urandom_range(4))
      0: v = $urandom;
      1: v = $urandom & 32'h7FFF_FFFF;
      2: v = $urandom_range(5000, 1);
      3: v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: v = $urandom_range(1) ? 32'd0 : 32'hFFFF_FFFF;
    endcase
    return v;
  endfunction

  // Mostly sound files of either kind with random content, the rest
  // damaged files and plain noise.
  task automatic queue_random_files(input int budget);
    int queued;
    int pick;
    queued = 0;
    while (queued < budget) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        make_png(pick_png_dim(), pick_png_dim(), $urandom_range(8));
      end else if (pick < 80) begin
        make_jpeg(8'(BYTE_SOF0 + $urandom_range(2)),
                  ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom_range(65535, 1)),
                  ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom_range(65535, 1)),
                  $urandom_range(3), 2, ($urandom_range(19) == 0) ? 300 : 16);
      end else begin
        make_noise($urandom_range(24, 1));
      end
      if (pick < 80 && $urandom_range(9) < 2) damage_file();
      queued += file_buf.size();
      emit_file();
    end
  endtask

  // The stimulus process pauses here until every report owed so far has come back.
  task automatic wait_for_reports();
    while (beat_q.size() != 0 || in_tvalid || due_reports.size() != 0) @(negedge clk);
  endtask

  initial begin
    clear_header_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed files, with no idling on either side.
    make_png(32'd640, 32'd480, 0);
    emit_file();
    make_png(32'd0, 32'd0, 3);                     // zero size is still a size
    emit_file();
    make_png(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);     // largest size allowed
    emit_file();
    make_png(32'h8000_0000, 32'd1, 0);             // width one past the limit
    emit_file();
    make_png(32'd1, 32'hFFFF_FFFF, 5);             // height far past it
    emit_file();
    make_png(32'd9, 32'd9, 0);                     // one byte short of the height
    trim_file(23);
    emit_file();
    make_png(32'd9, 32'd9, 0);                     // bare signature
    trim_file(8);
    emit_file();
    make_png(32'd9, 32'd9, 0);                     // too short to be a signature
    trim_file(7);
    emit_file();
    make_noise(1);                                 // one-byte files
    file_buf[0] = BYTE_FF;
    emit_file();
    file_buf[0] = 8'h00;
    emit_file();
    make_jpeg(BYTE_SOF0, 16'd8, 16'd8, 0, 2, 2);   // SOI and nothing else
    trim_file(2);
    emit_file();
    file_buf.push_back(BYTE_FF);                   // SOI followed straight by EOI
    file_buf.push_back(BYTE_EOI);
    emit_file();
    make_jpeg(BYTE_SOF0, 16'd480, 16'd640, 1, 2, 8);
    emit_file();
    make_jpeg(BYTE_SOF1, 16'hFFFF, 16'hFFFF, 2, 2, 2);  // empty segments
    emit_file();
    make_jpeg(BYTE_SOF2, 16'd1, 16'd1, 1, 260, 300);    // length high byte set
    emit_file();
    make_jpeg(BYTE_SOF0, 16'd0, 16'd77, 0, 2, 2);       // zero height
    emit_file();
    make_jpeg(BYTE_SOF0, 16'd77, 16'd0, 0, 2, 2);       // zero width
    emit_file();
    make_jpeg(BYTE_SOF0, 16'd5, 16'd5, 0, 2, 2);        // no FF where a marker belongs
    file_buf[2] = 8'h00;
    emit_file();
    make_jpeg(BYTE_SOF0, 16'd5, 16'd5, 1, 2, 8);        // segment length of zero
    file_buf[4] = 8'h00;
    file_buf[5] = 8'h00;
    emit_file();
    file_buf[5] = 8'h01;                                // and of one
    emit_file();
    make_jpeg(BYTE_SOF0, 16'd300, 16'd200, 0, 2, 2);    // ends before the width
    trim_file(8);
    file_buf.push_back(BYTE_FF);
    file_buf.push_back(BYTE_EOI);
    emit_file();
    make_jpeg(BYTE_SOF1, 16'd10, 16'd20, 1, 2, 6);      // EOI missing its last byte
    trim_file(file_buf.size() - 1);
    emit_file();
    make_noise(30);                                     // all clear, then all set
    foreach (file_buf[i]) file_buf[i] = 8'h00;
    emit_file();
    foreach (file_buf[i]) file_buf[i] = 8'hFF;
    emit_file();
    wait_for_reports();

    // Random files under each idling pattern in turn.
    queue_random_files(100);
    wait_for_reports();
    send_idle_pct = 84;
    queue_random_files(100);
    wait_for_reports();
    send_idle_pct  = 0;
    recv_stall_pct = 84;
    queue_random_files(100);
    wait_for_reports();
    send_idle_pct  = 28;
    recv_stall_pct = 28;
    queue_random_files(100);
    wait_for_reports();

    // Back-pressure: short files pile up behind a receiver that refuses
    // everything for a long stretch, so the input has to stall.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_phase     = TP_BACKPRESSURE;
    repeat (40) begin
      make_noise($urandom_range(3, 1));
      emit_file();
    end
    wait_for_reports();

    // Let any stray report beat show up before the verdict.
    repeat (10) @(negedge clk);
    if (fault_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ihs_pkg.sv
hw/rtl/ihs_jpeg_walk.sv
hw/rtl/ihs_classify.sv
hw/rtl/image_header_size_sniffer.sv
sim/tb.sv
